FILE: hw/rtl/vas_pkg.sv
// Package: widths, register map, reset values and frame class codes of the segmenter.
`timescale 1ns / 1ps
`default_nettype none

package vas_pkg;

	localparam int PROB_W  = 17;
	localparam int LEN_W   = 10;
	localparam int SAMP_W  = 24;
	localparam int CNT_W   = 40;
	localparam int CLASS_W = 2;

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// largest frame length taken as is; longer frames saturate
	localparam logic [LEN_W-1:0] MAX_FRAME = 10'd512;

	localparam logic [2:0] REG_START_THR   = 3'd0;
	localparam logic [2:0] REG_RELEASE     = 3'd1;
	localparam logic [2:0] REG_MIN_SILENCE = 3'd2;
	localparam logic [2:0] REG_PAD_LEFT    = 3'd3;
	localparam logic [2:0] REG_PAD_RIGHT   = 3'd4;

	localparam logic [PROB_W-1:0] START_THR_RST = 17'd32768;
	localparam logic [PROB_W-1:0] RELEASE_RST   = 17'd9830;
	localparam logic [SAMP_W-1:0] SAMP_RST      = 24'd0;

	localparam logic [CLASS_W-1:0] CLS_SILENCE  = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_START    = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_CONTINUE = 2'd2;
	localparam logic [CLASS_W-1:0] CLS_END      = 2'd3;

endpackage

`default_nettype wire

FILE: hw/rtl/voice_activity_segmenter_core.sv
// Top level: hysteresis and hangover speech segmenter with APB register port.
//
// Usage: one item on the s_ channel is one audio frame (speech probability and
// frame length in samples). For every frame one item leaves on the m_ channel:
// the frame class in m_tuser and the start or end sample in m_tdata (zero for
// silence and continuing speech).
// Pipeline: the frame is captured in an input register and its result is
// registered in the output register, which holds it until m_tready is high.
// Throughput: one frame per cycle while m_tready stays high, set by the single pass
// through the 40-bit counter add and the boundary subtract and compares.
// Stall: while m_tready is low the result holds in the output register and
// one more frame may wait in the input register; s_tready then drops.
// Reset: arst_n clears the sample counter, speech state and silence mark and
// loads the register defaults (threshold 32768, beam 9830, others 0).
// Registers (byte address 4*i): start_threshold, release_beam,
// min_silence_samples, pad_left_samples, pad_right_samples. Write only while
// no frame is in flight.
`timescale 1ns / 1ps
`default_nettype none

module voice_activity_segmenter_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// config
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [vas_pkg::APB_AW-1:0]  paddr,
	input  wire logic [vas_pkg::APB_DW-1:0]  pwdata,
	output logic      [vas_pkg::APB_DW-1:0]  prdata,
	output logic                             pready,
	// frames in
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [31:0]                 s_tdata,   // [16:0] speech_prob, [26:17] frame_len
	// results out
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic      [39:0]                 m_tdata,   // [39:0] boundary_sample
	output logic      [1:0]                  m_tuser    // [1:0] frame_class
);

	localparam int PW = vas_pkg::PROB_W;
	localparam int LW = vas_pkg::LEN_W;
	localparam int SW = vas_pkg::SAMP_W;
	localparam int CW = vas_pkg::CNT_W;

	// config registers
	logic [PW-1:0] start_thr_q;
	logic [PW-1:0] release_q;
	logic [SW-1:0] min_sil_q;
	logic [SW-1:0] pad_left_q;
	logic [SW-1:0] pad_right_q;

	// segmenter state
	logic          in_speech_q;
	logic [CW-1:0] mark_q;
	logic [CW-1:0] count_q;

	// input stage
	logic          valid_s1;
	logic [PW-1:0] prob_s1;
	logic [LW-1:0] len_s1;

	// output stage
	logic                        valid_s2;
	logic [vas_pkg::CLASS_W-1:0] cls_s2;
	logic [CW-1:0]               bnd_s2;

	logic cfg_wr;
	logic advance;

	logic [LW-1:0]               len_sat;
	logic [CW-1:0]               cnt_new;
	logic [CW-1:0]               back;
	logic [CW-1:0]               start_b;
	logic [CW-1:0]               end_b;
	logic [CW-1:0]               mark_eff;
	logic [CW-1:0]               sil_len;
	logic                        hold;
	logic                        end_hit;
	logic [vas_pkg::CLASS_W-1:0] cls_d;
	logic [CW-1:0]               bnd_d;
	logic                        in_speech_d;
	logic [CW-1:0]               mark_d;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_thr_q <= vas_pkg::START_THR_RST;
			release_q   <= vas_pkg::RELEASE_RST;
			min_sil_q   <= vas_pkg::SAMP_RST;
			pad_left_q  <= vas_pkg::SAMP_RST;
			pad_right_q <= vas_pkg::SAMP_RST;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				vas_pkg::REG_START_THR:   start_thr_q <= pwdata[PW-1:0];
				vas_pkg::REG_RELEASE:     release_q   <= pwdata[PW-1:0];
				vas_pkg::REG_MIN_SILENCE: min_sil_q   <= pwdata[SW-1:0];
				vas_pkg::REG_PAD_LEFT:    pad_left_q  <= pwdata[SW-1:0];
				vas_pkg::REG_PAD_RIGHT:   pad_right_q <= pwdata[SW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			vas_pkg::REG_START_THR:   prdata = {15'd0, start_thr_q};
			vas_pkg::REG_RELEASE:     prdata = {15'd0, release_q};
			vas_pkg::REG_MIN_SILENCE: prdata = {8'd0, min_sil_q};
			vas_pkg::REG_PAD_LEFT:    prdata = {8'd0, pad_left_q};
			vas_pkg::REG_PAD_RIGHT:   prdata = {8'd0, pad_right_q};
			default:                  prdata = '0;
		endcase
	end

	// handshake: input stage moves on when the output register is free or drains
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			prob_s1 <= s_tdata[PW-1:0];
			len_s1  <= s_tdata[PW+LW-1:PW];
		end
	end

	// per-frame decision
	always_comb begin
		len_sat  = (len_s1 > vas_pkg::MAX_FRAME) ? vas_pkg::MAX_FRAME : len_s1;
		cnt_new  = count_q + {{(CW-LW){1'b0}}, len_sat};
		back     = {{(CW-LW){1'b0}}, len_sat} + {{(CW-SW){1'b0}}, pad_left_q};
		start_b  = (cnt_new > back) ? (cnt_new - back) : '0;
		end_b    = cnt_new + {{(CW-SW){1'b0}}, pad_right_q};
		hold     = ({1'b0, prob_s1} + {1'b0, release_q}) >= {1'b0, start_thr_q};
		mark_eff = (mark_q == '0) ? cnt_new : mark_q;
		sil_len  = cnt_new - mark_eff;
		end_hit  = sil_len >= {{(CW-SW){1'b0}}, min_sil_q};

		cls_d       = vas_pkg::CLS_SILENCE;
		bnd_d       = '0;
		in_speech_d = in_speech_q;
		mark_d      = mark_q;
		priority if (!in_speech_q) begin
			if (prob_s1 >= start_thr_q) begin
				cls_d       = vas_pkg::CLS_START;
				bnd_d       = start_b;
				in_speech_d = 1'b1;
			end
		end else if (hold) begin
			cls_d  = vas_pkg::CLS_CONTINUE;
			mark_d = '0;
		end else if (end_hit) begin
			cls_d       = vas_pkg::CLS_END;
			bnd_d       = end_b;
			in_speech_d = 1'b0;
			mark_d      = '0;
		end else begin
			mark_d = mark_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_speech_q <= 1'b0;
			mark_q      <= '0;
			count_q     <= '0;
		end else if (advance) begin
			in_speech_q <= in_speech_d;
			mark_q      <= mark_d;
			count_q     <= cnt_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cls_s2 <= cls_d;
			bnd_s2 <= bnd_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = bnd_s2;
	assign m_tuser  = cls_s2;

	// checks
	a_start_enters: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cls_d == vas_pkg::CLS_START |=> in_speech_q)
		else $error("speech start did not enter speech");

	a_end_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cls_d == vas_pkg::CLS_END |=> !in_speech_q && mark_q == '0)
		else $error("speech end left state behind");

	a_no_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == vas_pkg::CLS_SILENCE || m_tuser == vas_pkg::CLS_CONTINUE)
		|-> m_tdata == '0)
		else $error("boundary reported without start or end");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_tready && valid_s1 |-> !s_tready && !advance)
		else $error("input taken while both stages are full");

endmodule

`default_nettype wire

FILE: verif/voice_activity_segmenter_core_tb.sv
// Testbench: checks the speech segmenter's frame classes and boundaries against a local predictor.
`timescale 1ns / 1ps

module voice_activity_segmenter_core_tb;

	localparam int PW = vas_pkg::PROB_W;
	localparam int LW = vas_pkg::LEN_W;
	localparam int SW = vas_pkg::SAMP_W;
	localparam int CW = vas_pkg::CNT_W;

	typedef struct packed {
		logic [vas_pkg::CLASS_W-1:0] cls;
		logic [CW-1:0]               boundary;
	} segment_t;

	localparam int DRAIN_LIMIT = 20000;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [vas_pkg::APB_AW-1:0]   paddr = '0;
	logic [vas_pkg::APB_DW-1:0]   pwdata = '0;
	logic [vas_pkg::APB_DW-1:0]   prdata;
	logic                         pready;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [31:0]                  s_tdata = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [39:0]                  m_tdata;
	logic [1:0]                   m_tuser;

	// predictor state and register shadow
	logic                speaking = 1'b0;
	logic [CW-1:0]       silence_mark = '0;
	logic [CW-1:0]       sample_cnt = '0;
	logic [PW-1:0]       thr_cfg = vas_pkg::START_THR_RST;
	logic [PW-1:0]       beam_cfg = vas_pkg::RELEASE_RST;
	logic [SW-1:0]       min_sil_cfg = vas_pkg::SAMP_RST;
	logic [SW-1:0]       pad_left_cfg = vas_pkg::SAMP_RST;
	logic [SW-1:0]       pad_right_cfg = vas_pkg::SAMP_RST;

	segment_t            expected_segments[$];

	int                  tx_idle_pct = 0;
	int                  rx_stall_pct = 0;
	logic                calm = 1'b0;
	int                  mismatches = 0;
	int                  frames_sent = 0;
	int                  results_seen = 0;
	int                  class_seen[4] = '{0, 0, 0, 0};

	voice_activity_segmenter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #2 clk = ~clk;

	initial begin
		#1600000;
		$display("tb: failure");
		$finish;
	end

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
	endtask

	function automatic void segment_frame(input logic [PW-1:0] prob,
			input logic [LW-1:0] raw_len);
		logic [LW-1:0] len;
		logic [CW-1:0] back;
		logic [PW:0]   level;
		segment_t      res;
		len = (raw_len > vas_pkg::MAX_FRAME) ? vas_pkg::MAX_FRAME : raw_len;
		res.cls = vas_pkg::CLS_SILENCE;
		res.boundary = '0;
		sample_cnt = sample_cnt + {30'd0, len};
		if (!speaking) begin
			if (prob >= thr_cfg) begin
				back = {30'd0, len} + {16'd0, pad_left_cfg};
				speaking = 1'b1;
				res.cls = vas_pkg::CLS_START;
				res.boundary = (sample_cnt > back) ? sample_cnt - back : '0;
			end
		end else begin
			level = {1'b0, prob} + {1'b0, beam_cfg};
			if (level >= {1'b0, thr_cfg}) begin
				silence_mark = '0;
				res.cls = vas_pkg::CLS_CONTINUE;
			end else begin
				if (silence_mark == '0) begin
					silence_mark = sample_cnt;
				end
				if (sample_cnt - silence_mark >= {16'd0, min_sil_cfg}) begin
					res.boundary = sample_cnt + {16'd0, pad_right_cfg};
					silence_mark = '0;
					speaking = 1'b0;
					res.cls = vas_pkg::CLS_END;
				end
			end
		end
		expected_segments.push_back(res);
	endfunction

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			segment_frame(s_tdata[16:0], s_tdata[26:17]);
		end
	end

	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99, 0) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		segment_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			class_seen[m_tuser]++;
			if (expected_segments.size() == 0) begin
				flag_error($sformatf("unexpected result: class %0d sample %0d",
					m_tuser, m_tdata));
			end else begin
				want = expected_segments.pop_front();
				if (m_tuser !== want.cls) begin
					flag_error($sformatf("frame_class exp %0d got %0d", want.cls, m_tuser));
				end
				if (m_tdata !== want.boundary) begin
					flag_error($sformatf("boundary_sample exp %0d got %0d",
						want.boundary, m_tdata));
				end
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			vas_pkg::REG_START_THR:   thr_cfg = value[PW-1:0];
			vas_pkg::REG_RELEASE:     beam_cfg = value[PW-1:0];
			vas_pkg::REG_MIN_SILENCE: min_sil_cfg = value[SW-1:0];
			vas_pkg::REG_PAD_LEFT:    pad_left_cfg = value[SW-1:0];
			vas_pkg::REG_PAD_RIGHT:   pad_right_cfg = value[SW-1:0];
			default: ;
		endcase
	endtask

	task automatic send_frame(input logic [PW-1:0] prob, input logic [LW-1:0] len);
		if (!calm) begin
			while ($urandom_range(99, 0) < tx_idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, len, prob};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		frames_sent++;
	endtask

	task automatic drain;
		int waited = 0;
		s_tvalid <= 1'b0;
		while (expected_segments.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_segments.size() != 0) begin
			flag_error($sformatf("%0d results never arrived", expected_segments.size()));
			expected_segments.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic load_config(input logic [31:0] thr, input logic [31:0] beam,
			input logic [31:0] min_sil, input logic [31:0] pad_l, input logic [31:0] pad_r);
		drain();
		write_reg(vas_pkg::REG_START_THR, thr);
		write_reg(vas_pkg::REG_RELEASE, beam);
		write_reg(vas_pkg::REG_MIN_SILENCE, min_sil);
		write_reg(vas_pkg::REG_PAD_LEFT, pad_l);
		write_reg(vas_pkg::REG_PAD_RIGHT, pad_r);
	endtask

	// reset values: exact threshold and release level edges, zero-length frames
	task automatic test_reset_defaults;
		send_frame(17'd32767, 10'd0);
		send_frame(17'd32768, 10'd0);
		send_frame(17'd22938, 10'd0);
		send_frame(17'd22937, 10'd0);
		drain();
	endtask

	// a silence mark taken at counter zero reads as unset and is retaken
	task automatic test_mark_at_zero;
		load_config(32'd32768, 32'd9830, 32'd3, 32'd0, 32'd0);
		send_frame(17'd65536, 10'd0);
		send_frame(17'd0, 10'd0);
		send_frame(17'd0, 10'd2);
		send_frame(17'd0, 10'd3);
		drain();
	endtask

	// extreme field values and long frames saturating
	task automatic test_field_extremes;
		load_config(32'd65536, 32'd0, 32'd0, 32'd0, 32'd0);
		send_frame(17'd131071, 10'd1023);
		send_frame(17'd0, 10'd513);
		send_frame(17'd65535, 10'd1);
		send_frame(17'd65536, 10'd512);
		send_frame(17'd131071, 10'd511);
		send_frame(17'h0aaaa, 10'h2aa);
		drain();
	endtask

	// beam above threshold: any probability keeps speech going
	task automatic test_negative_release;
		load_config(32'd1000, 32'd65536, 32'd0, 32'd0, 32'd0);
		send_frame(17'd1000, 10'd100);
		send_frame(17'd0, 10'd100);
		send_frame(17'd0, 10'd0);
		drain();
	endtask

	// threshold above the nominal probability range
	task automatic test_above_range;
		load_config(32'd131071, 32'd0, 32'd0, 32'd0, 32'd0);
		send_frame(17'd131070, 10'd10);
		send_frame(17'd131071, 10'd10);
		send_frame(17'd131070, 10'd10);
		drain();
	endtask

	// start clamped at zero, hangover with false ends, mark cleared, padded end
	task automatic test_padding_and_hangover;
		load_config(32'd32768, 32'd9830, 32'd1000, 32'hffffff, 32'hffffff);
		send_frame(17'd40000, 10'd200);
		send_frame(17'd100, 10'd300);
		send_frame(17'd30000, 10'd300);
		send_frame(17'd100, 10'd512);
		send_frame(17'd100, 10'd512);
		send_frame(17'd100, 10'd512);
		drain();
	endtask

	function automatic logic [31:0] pick_value(input int unsigned lo, input int unsigned hi,
			input int unsigned top);
		case ($urandom_range(7, 0))
			0: return 32'd0;
			1: return top;
			default: return $urandom_range(hi, lo);
		endcase
	endfunction

	// 0 above threshold, 1 between release level and threshold, 2 below, else any
	function automatic logic [PW-1:0] pick_prob(input int kind);
		int unsigned thr;
		int unsigned rel;
		thr = 32'(thr_cfg);
		rel = (thr_cfg > beam_cfg) ? 32'(thr_cfg - beam_cfg) : 32'd0;
		case (kind)
			0: return (thr + 4096 > 131071) ? PW'($urandom_range(131071, thr))
					: PW'($urandom_range(thr + 4096, thr));
			1: return (rel < thr) ? PW'($urandom_range(thr - 1, rel))
					: PW'($urandom_range(131071, 0));
			2: return (rel > 0) ? PW'($urandom_range(rel - 1, 0)) : 17'd0;
			default: return PW'($urandom_range(131071, 0));
		endcase
	endfunction

	function automatic logic [LW-1:0] pick_len;
		int unsigned r;
		r = $urandom_range(99, 0);
		if (r < 8) return 10'd0;
		if (r < 15) return LW'($urandom_range(1023, 513));
		if (r < 20) return vas_pkg::MAX_FRAME;
		return LW'($urandom_range(512, 1));
	endfunction

	task automatic test_random_phase(input int phase, input int n_items);
		int sent = 0;
		int kind;
		int run_len;
		int r;
		case (phase % 4)
			0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			1: begin tx_idle_pct = 59; rx_stall_pct = 0;  end
			2: begin tx_idle_pct = 0;  rx_stall_pct = 59; end
			default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
		endcase
		case (phase)
			0: load_config(32'd32768, 32'd9830, $urandom_range(1500, 0),
					$urandom_range(2000, 0), $urandom_range(2000, 0));
			3: load_config(32'd65536, 32'd65536, 32'hffffff, 32'hffffff, 32'hffffff);
			6: load_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
			default: load_config(pick_value(8192, 57344, 65536), pick_value(0, 16384, 65536),
					pick_value(0, 2048, 32'hffffff), pick_value(0, 4096, 32'hffffff),
					pick_value(0, 4096, 32'hffffff));
		endcase
		while (sent < n_items) begin
			r = $urandom_range(99, 0);
			kind = (r < 40) ? 0 : (r < 55) ? 1 : (r < 85) ? 2 : 3;
			run_len = $urandom_range(12, 1);
			calm = ($urandom_range(4, 0) == 0);
			for (int i = 0; i < run_len && sent < n_items; i++) begin
				send_frame(pick_prob(($urandom_range(9, 0) == 0) ? 3 : kind), pick_len());
				sent++;
			end
		end
		calm = 1'b0;
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_mark_at_zero();
		test_field_extremes();
		test_negative_release();
		test_above_range();
		test_padding_and_hangover();
		for (int phase = 0; phase < 8; phase++) begin
			test_random_phase(phase, 250);
		end
		drain();
		$display("covered %0d frames, %0d results: %0d starts, %0d ends,",
			frames_sent, results_seen, class_seen[vas_pkg::CLS_START],
			class_seen[vas_pkg::CLS_END]);
		$display("%0d continues, %0d silent; reset values, directed edges, 8 random sets",
			class_seen[vas_pkg::CLS_CONTINUE], class_seen[vas_pkg::CLS_SILENCE]);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
